// ===== rtl/ple_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, codes and types for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int MODE_W      = 2;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int LEN_W       = 7;
  localparam int CAPACITY_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         pos_m1;
    logic [POS_W-1:0]         last_idx;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/ple_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_req_if / ple_rsp_if
// Valid/ready channels for requests and results of the list engine.
// ----------------------------------------------------------------------------
interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::MODE_W-1:0]        mode;
  logic signed [ple_pkg::VAL_W-1:0]  value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ple_pkg::STATUS_W-1:0]      status;
  logic                              has_entry;
  logic signed [ple_pkg::VAL_W-1:0]  entry_value;
  logic [ple_pkg::POS_W-1:0]         entry_index;
  logic [ple_pkg::LEN_W-1:0]         length;
  logic                              last;

  modport source (output valid, status, has_entry, entry_value, entry_index, length, last,
                  input ready);
  modport sink   (input valid, status, has_entry, entry_value, entry_index, length, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/ple_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds, takes a new value, or takes a neighbor's or the head cell's value.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int IDX = 0
) (
  input  wire logic                             clk,
  input  wire ple_pkg::cell_cmd_t               cmd,
  input  wire logic signed [ple_pkg::VAL_W-1:0] prev_data,
  input  wire logic signed [ple_pkg::VAL_W-1:0] next_data,
  input  wire logic signed [ple_pkg::VAL_W-1:0] head_data,
  output logic signed [ple_pkg::VAL_W-1:0]      data
);

  localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(IDX);

  logic signed [ple_pkg::VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      ple_pkg::CELL_INS: begin
        if (MY_IDX == cmd.pos_m1) begin
          data_next = cmd.value;
        end else if (MY_IDX > cmd.pos_m1) begin
          data_next = prev_data;
        end
      end
      ple_pkg::CELL_DEL: begin
        if (MY_IDX >= cmd.pos_m1) begin
          data_next = next_data;
        end
      end
      ple_pkg::CELL_ROT: begin
        if (MY_IDX == cmd.last_idx) begin
          data_next = head_data;
        end else if (MY_IDX < cmd.last_idx) begin
          data_next = next_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// insert/delete: one result, registered in the cycle after the request transfer
// read-out: one result per entry, at least one, one per cycle unless the output stalls;
//   the chain rotates once per emitted entry, count rotations restore the order
// next request is taken once the last result is loaded and the output is free
// reset clears the entry count and output valid; cell contents are not cleared
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [ple_pkg::POS_W:0] CAP_EXT = (ple_pkg::POS_W + 1)'(CAPACITY);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t                           state;
  logic [CW-1:0]                    count;
  logic [IW-1:0]                    rd_idx;
  logic                             out_valid;
  logic [ple_pkg::STATUS_W-1:0]     out_status;
  logic                             out_has_entry;
  logic signed [ple_pkg::VAL_W-1:0] out_entry_value;
  logic [ple_pkg::POS_W-1:0]        out_entry_index;
  logic [ple_pkg::LEN_W-1:0]        out_length;
  logic                             out_last;

  logic                             out_free;
  logic                             fire;
  logic [ple_pkg::POS_W:0]          cnt_ext;
  logic [ple_pkg::POS_W:0]          pos_ext;
  logic [ple_pkg::STATUS_W-1:0]     ins_status;
  logic [ple_pkg::STATUS_W-1:0]     del_status;
  logic [ple_pkg::POS_W-1:0]        last_idx;
  logic                             rd_last;
  ple_pkg::cell_cmd_t               cmd;
  logic signed [ple_pkg::VAL_W-1:0] cell_data [CAPACITY];

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign fire      = req.valid && req.ready;

  assign cnt_ext  = (ple_pkg::POS_W + 1)'(count);
  assign pos_ext  = {1'b0, req.position};
  assign last_idx = ple_pkg::POS_W'(count) - ple_pkg::POS_W'(1);
  assign rd_last  = (ple_pkg::POS_W'(rd_idx) == last_idx);

  always_comb begin
    if (req.position == '0 || pos_ext > cnt_ext + (ple_pkg::POS_W + 1)'(1)) begin
      ins_status = ple_pkg::ST_NOPE;
    end else if (cnt_ext >= CAP_EXT) begin
      ins_status = ple_pkg::ST_FULL;
    end else begin
      ins_status = ple_pkg::ST_OK;
    end
    if (count == '0 || req.position == '0 || pos_ext > cnt_ext) begin
      del_status = ple_pkg::ST_NOPE;
    end else begin
      del_status = ple_pkg::ST_OK;
    end
  end

  always_comb begin
    cmd.op       = ple_pkg::CELL_HOLD;
    cmd.value    = req.value;
    cmd.pos_m1   = req.position - ple_pkg::POS_W'(1);
    cmd.last_idx = last_idx;
    if (fire && req.mode == ple_pkg::MODE_INSERT && ins_status == ple_pkg::ST_OK) begin
      cmd.op = ple_pkg::CELL_INS;
    end else if (fire && req.mode == ple_pkg::MODE_DELETE &&
                 del_status == ple_pkg::ST_OK) begin
      cmd.op = ple_pkg::CELL_DEL;
    end else if (state == S_READ && out_free) begin
      cmd.op = ple_pkg::CELL_ROT;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ple_pkg::VAL_W-1:0] prev_d;
    logic signed [ple_pkg::VAL_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign next_d = '0;
    end else begin : g_next
      assign next_d = cell_data[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .prev_data (prev_d),
      .next_data (next_d),
      .head_data (cell_data[0]),
      .data      (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (fire) begin
            out_valid       <= !(req.mode == ple_pkg::MODE_READ && count != '0);
            out_has_entry   <= 1'b0;
            out_entry_value <= '0;
            out_entry_index <= '0;
            out_last        <= 1'b1;
            case (req.mode)
              ple_pkg::MODE_INSERT: begin
                out_status <= ins_status;
                if (ins_status == ple_pkg::ST_OK) begin
                  count      <= CW'(count + 1'b1);
                  out_length <= ple_pkg::LEN_W'(count) + ple_pkg::LEN_W'(1);
                end else begin
                  out_length <= ple_pkg::LEN_W'(count);
                end
              end
              ple_pkg::MODE_DELETE: begin
                out_status <= del_status;
                if (del_status == ple_pkg::ST_OK) begin
                  count      <= CW'(count - 1'b1);
                  out_length <= ple_pkg::LEN_W'(count) - ple_pkg::LEN_W'(1);
                end else begin
                  out_length <= ple_pkg::LEN_W'(count);
                end
              end
              ple_pkg::MODE_READ: begin
                out_status <= ple_pkg::ST_OK;
                out_length <= ple_pkg::LEN_W'(count);
                if (count != '0) begin
                  rd_idx <= '0;
                  state  <= S_READ;
                end
              end
              default: begin
                out_status <= ple_pkg::ST_NOPE;
                out_length <= ple_pkg::LEN_W'(count);
              end
            endcase
          end else if (rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= ple_pkg::ST_OK;
            out_has_entry   <= 1'b1;
            out_entry_value <= cell_data[0];
            out_entry_index <= ple_pkg::POS_W'(rd_idx) + ple_pkg::POS_W'(1);
            out_length      <= ple_pkg::LEN_W'(count);
            out_last        <= rd_last;
            rd_idx          <= IW'(rd_idx + 1'b1);
            if (rd_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.has_entry   = out_has_entry;
  assign rsp.entry_value = out_entry_value;
  assign rsp.entry_index = out_entry_index;
  assign rsp.length      = out_length;
  assign rsp.last        = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (ple_pkg::POS_W + 1)'(count) <= CAP_EXT)
    else $error("entry count above capacity");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (fire && req.mode == ple_pkg::MODE_READ) |=> count == $past(count))
    else $error("read-out changed the entry count");

  a_entry_index: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.has_entry) |->
      (rsp.entry_index != '0 && rsp.entry_index <= rsp.length))
    else $error("emitted entry index outside the list");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !req.ready)
    else $error("request taken during read-out");

endmodule
`default_nettype wire

// ===== dv/positional_list_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives insert, delete and read-out requests into the list engine through
// its valid/ready channels and checks every result against a shadow copy of
// the list kept in the bench. A short table of directed requests comes first,
// then random traffic in phases with different sender and receiver idling.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;

  localparam int CAPACITY = ple_pkg::CAPACITY_DEF;
  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int N_DIRECTED = 24;

  typedef struct packed {
    logic [ple_pkg::MODE_W-1:0]        mode;
    logic signed [ple_pkg::VAL_W-1:0]  value;
    logic [ple_pkg::POS_W-1:0]         position;
    logic [4:0]                        reps;
    logic                              fixed;
    logic [ple_pkg::STATUS_W-1:0]      status;
    logic [ple_pkg::LEN_W-1:0]         length;
  } list_cmd_t;

  typedef struct {
    logic [ple_pkg::STATUS_W-1:0]      status;
    logic                              has_entry;
    logic signed [ple_pkg::VAL_W-1:0]  entry_value;
    logic [ple_pkg::POS_W-1:0]         entry_index;
    logic [ple_pkg::LEN_W-1:0]         length;
    logic                              last;
    longint unsigned                   stamp;
  } list_rsp_t;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic signed [ple_pkg::VAL_W-1:0] list_vals [CAPACITY];
  int                               list_len;
  list_rsp_t                        list_results_q [$];
  int                               err_count;
  int                               send_idle_pct;
  int                               recv_stall_pct;

  list_cmd_t directed_cmds [N_DIRECTED] = '{
    '{ple_pkg::MODE_READ,   32'sh0000_0000, 7'd0,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd0},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd1,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd0},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0005, 7'd0,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd0},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0005, 7'd2,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd0},
    '{ple_pkg::MODE_INSERT, 32'sh7fff_ffff, 7'd1,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd1},
    '{ple_pkg::MODE_INSERT, 32'sh8000_0000, 7'd1,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd2},
    '{ple_pkg::MODE_INSERT, 32'shffff_ffff, 7'd3,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd3},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0000, 7'd2,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd4},
    '{ple_pkg::MODE_READ,   32'sh0000_0000, 7'd0,   5'd1,  1'b0, ple_pkg::ST_OK,   7'd0},
    '{MODE_SPARE,           32'sh5555_5555, 7'd127, 5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd4},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd0,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd4},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd5,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd4},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd127, 5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd4},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd1,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd3},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd3,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd2},
    '{ple_pkg::MODE_INSERT, 32'sh1234_0000, 7'd2,   5'd14, 1'b0, ple_pkg::ST_OK,   7'd0},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0011, 7'd17,  5'd1,  1'b1, ple_pkg::ST_FULL, 7'd16},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0012, 7'd18,  5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd16},
    '{ple_pkg::MODE_INSERT, 32'sh0000_0013, 7'd0,   5'd1,  1'b1, ple_pkg::ST_NOPE, 7'd16},
    '{ple_pkg::MODE_READ,   32'sh0000_0000, 7'd0,   5'd1,  1'b0, ple_pkg::ST_OK,   7'd0},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd16,  5'd1,  1'b1, ple_pkg::ST_OK,   7'd15},
    '{ple_pkg::MODE_INSERT, 32'shaaaa_aaaa, 7'd8,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd16},
    '{ple_pkg::MODE_DELETE, 32'sh0000_0000, 7'd1,   5'd16, 1'b0, ple_pkg::ST_OK,   7'd0},
    '{ple_pkg::MODE_READ,   32'sh0000_0000, 7'd0,   5'd1,  1'b1, ple_pkg::ST_OK,   7'd0}
  };

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [ple_pkg::VAL_W-1:0] got,
                             input logic [ple_pkg::VAL_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic void push_list_result(input logic [ple_pkg::STATUS_W-1:0] status,
                                           input logic has_entry,
                                           input logic signed [ple_pkg::VAL_W-1:0] entry_value,
                                           input int entry_index, input logic last);
    list_rsp_t r;
    r.status      = status;
    r.has_entry   = has_entry;
    r.entry_value = entry_value;
    r.entry_index = ple_pkg::POS_W'(entry_index);
    r.length      = ple_pkg::LEN_W'(list_len);
    r.last        = last;
    r.stamp       = $time;
    list_results_q.push_back(r);
  endfunction

  function automatic void apply_list_op(input logic [ple_pkg::MODE_W-1:0] mode,
                                        input logic signed [ple_pkg::VAL_W-1:0] value,
                                        input logic [ple_pkg::POS_W-1:0] position);
    int pos;
    pos = int'(position);
    case (mode)
      ple_pkg::MODE_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          push_list_result(ple_pkg::ST_NOPE, 1'b0, '0, 0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          push_list_result(ple_pkg::ST_FULL, 1'b0, '0, 0, 1'b1);
        end else begin
          for (int i = list_len; i >= pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos-1] = value;
          list_len++;
          push_list_result(ple_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
        end
      end
      ple_pkg::MODE_DELETE: begin
        if (list_len == 0 || pos < 1 || pos > list_len) begin
          push_list_result(ple_pkg::ST_NOPE, 1'b0, '0, 0, 1'b1);
        end else begin
          for (int i = pos - 1; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          push_list_result(ple_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
        end
      end
      ple_pkg::MODE_READ: begin
        if (list_len == 0) begin
          push_list_result(ple_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            push_list_result(ple_pkg::ST_OK, 1'b1, list_vals[i], i + 1, i + 1 == list_len);
        end
      end
      default: begin
        push_list_result(ple_pkg::ST_NOPE, 1'b0, '0, 0, 1'b1);
      end
    endcase
  endfunction

  task automatic pick_random_request(output logic [ple_pkg::MODE_W-1:0] mode,
                                     output logic signed [ple_pkg::VAL_W-1:0] value,
                                     output logic [ple_pkg::POS_W-1:0] position);
    int r;
    int ins_pct;
    r        = $urandom_range(99);
    value    = $urandom;
    position = ple_pkg::POS_W'($urandom_range(127));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = 32'sh0000_0000;
        default: value = 32'shffff_ffff;
      endcase
    end
    if (r < 3) begin
      mode = MODE_SPARE;
    end else if (r < 13) begin
      mode = ple_pkg::MODE_READ;
    end else begin
      ins_pct = (list_len < 4) ? 75 : (list_len >= CAPACITY - 1) ? 35 : 55;
      mode = ($urandom_range(99) < ins_pct) ? ple_pkg::MODE_INSERT : ple_pkg::MODE_DELETE;
      // mostly legal positions, the rest is noise over the full field
      if ($urandom_range(99) < 88) begin
        if (mode == ple_pkg::MODE_INSERT) begin
          position = ple_pkg::POS_W'($urandom_range(list_len + 1, 1));
        end else if (list_len > 0) begin
          position = ple_pkg::POS_W'($urandom_range(list_len, 1));
        end
      end
    end
  endtask

  // returns in the time step of the transfer
  task automatic send_request(input logic [ple_pkg::MODE_W-1:0] mode,
                              input logic signed [ple_pkg::VAL_W-1:0] value,
                              input logic [ple_pkg::POS_W-1:0] position);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.value    <= value;
    req_ch.position <= position;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_list_op(mode, value, position);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (list_results_q.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("positional_list_engine_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    list_rsp_t e;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (list_results_q.size() == 0 || list_results_q[0].stamp == $time) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = list_results_q.pop_front();
        check_field("status", ple_pkg::VAL_W'(rsp_ch.status), ple_pkg::VAL_W'(e.status));
        check_field("has_entry", ple_pkg::VAL_W'(rsp_ch.has_entry),
                    ple_pkg::VAL_W'(e.has_entry));
        check_field("entry_value", rsp_ch.entry_value, e.entry_value);
        check_field("entry_index", ple_pkg::VAL_W'(rsp_ch.entry_index),
                    ple_pkg::VAL_W'(e.entry_index));
        check_field("length", ple_pkg::VAL_W'(rsp_ch.length), ple_pkg::VAL_W'(e.length));
        check_field("last", ple_pkg::VAL_W'(rsp_ch.last), ple_pkg::VAL_W'(e.last));
      end
    end
  end

  initial begin
    logic [ple_pkg::MODE_W-1:0]       mode;
    logic signed [ple_pkg::VAL_W-1:0] value;
    logic [ple_pkg::POS_W-1:0]        position;
    int                               tail;

    req_ch.valid    = 1'b0;
    req_ch.mode     = ple_pkg::MODE_INSERT;
    req_ch.value    = '0;
    req_ch.position = '0;
    rst             = 1'b1;
    err_count       = 0;
    list_len        = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      for (int k = 0; k < int'(directed_cmds[i].reps); k++) begin
        send_request(directed_cmds[i].mode, directed_cmds[i].value + ple_pkg::VAL_W'(k),
                     directed_cmds[i].position);
        if (directed_cmds[i].fixed) begin
          tail = list_results_q.size() - 1;
          list_results_q[tail].status = directed_cmds[i].status;
          list_results_q[tail].length = directed_cmds[i].length;
        end
      end
    end
    drain_results();

    // no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 74 : (ph == 3) ? 16 : 0;
      recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 16 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        pick_random_request(mode, value, position);
        send_request(mode, value, position);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("positional_list_engine_tb: clean");
    end else begin
      $display("positional_list_engine_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
dv/positional_list_engine_tb.sv
